// File: rtl/rawdefrm_pkg.sv
package rawdefrm_pkg;

	// parse phase
	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_HEADER = 2'd1,
		PH_PIXELS = 2'd2,
		PH_IDLE   = 2'd3
	} phase_t;

	// result kinds
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_BLOCK  = 2'd1;
	localparam logic [1:0] KIND_ACCEPT = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	// block types
	localparam logic [2:0] BT_PRD     = 3'd0;
	localparam logic [2:0] BT_TTW     = 3'd1;
	localparam logic [2:0] BT_WBG     = 3'd2;
	localparam logic [2:0] BT_RIF     = 3'd3;
	localparam logic [2:0] BT_PAD     = 3'd4;
	localparam logic [2:0] BT_UNKNOWN = 3'd5;

	// reject causes
	localparam logic [1:0] FAIL_NONE    = 2'd0;
	localparam logic [1:0] FAIL_MAGIC   = 2'd1;
	localparam logic [1:0] FAIL_MISSING = 2'd2;
	localparam logic [1:0] FAIL_ODD     = 2'd3;

	// four-byte codes (a zero byte, then three characters), big-endian
	localparam logic [31:0] TAG_MAGIC = 32'h004d524d;
	localparam logic [31:0] TAG_PRD   = 32'h00505244;
	localparam logic [31:0] TAG_TTW   = 32'h00545457;
	localparam logic [31:0] TAG_WBG   = 32'h00574247;
	localparam logic [31:0] TAG_RIF   = 32'h00524946;
	localparam logic [31:0] TAG_PAD   = 32'h00504144;

	localparam logic [3:0] REQ_ALL = 4'hf;

	// PRD payload offsets of height and width, and the offset at which the payload position saturates
	localparam logic [3:0] POS_HEIGHT_HI = 4'd8;
	localparam logic [3:0] POS_HEIGHT_LO = 4'd9;
	localparam logic [3:0] POS_WIDTH_HI  = 4'd10;
	localparam logic [3:0] POS_WIDTH_LO  = 4'd11;
	localparam logic [3:0] POS_SAT       = 4'd15;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] pixel_value;
		logic [2:0]  block_type;
		logic [31:0] block_offset;
		logic [31:0] block_length;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [1:0]  fail_cause;
		logic        end_of_image;
		logic        last;
	} result_t;

	function automatic logic [2:0] classify(input logic [31:0] tag);
		logic [2:0] t;
		if (tag == TAG_PRD)      t = BT_PRD;
		else if (tag == TAG_TTW) t = BT_TTW;
		else if (tag == TAG_WBG) t = BT_WBG;
		else if (tag == TAG_RIF) t = BT_RIF;
		else if (tag == TAG_PAD) t = BT_PAD;
		else                     t = BT_UNKNOWN;
		return t;
	endfunction

	// header verdict
	function automatic result_t judge_result(input logic [3:0] req, input logic [15:0] w,
			input logic [15:0] h);
		result_t r;
		r = '0;
		if (req != REQ_ALL) begin
			r.kind = KIND_REJECT;
			r.fail_cause = FAIL_MISSING;
		end else if (w[0]) begin
			r.kind = KIND_REJECT;
			r.fail_cause = FAIL_ODD;
		end else begin
			r.kind = KIND_ACCEPT;
			r.image_width = w;
			r.image_height = h;
		end
		return r;
	endfunction

	// phase after the verdict
	function automatic phase_t judge_phase(input logic [3:0] req, input logic [15:0] w,
			input logic [15:0] h);
		phase_t p;
		if (req != REQ_ALL || w[0] || w == 16'd0 || h == 16'd0) p = PH_IDLE;
		else p = PH_PIXELS;
		return p;
	endfunction

endpackage

// File: rtl/raw_image_stream_deframer.sv
// channel | signals                                   | direction
// in      | in_valid, in_ready, start_of_file, data_byte | one file byte per request
// out     | out_valid, out_ready, kind .. last          | pixel, block record or verdict
//
// one byte is parsed per cycle: a single pass of logic from the parse state and the
// byte writes zero, one or two results into a four-entry output queue.
// in_ready is high while the queue has room for two results, so with out_ready held
// high a byte is taken every cycle; a stalled output side fills the queue and then
// holds off input. arst_n clears the parse state (magic check) and empties the queue.
module raw_image_stream_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        start_of_file,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [11:0] pixel_value,
	output logic [2:0]  block_type,
	output logic [31:0] block_offset,
	output logic [31:0] block_length,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [1:0]  fail_cause,
	output logic        end_of_image,
	output logic        last
);

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// parse state
	rawdefrm_pkg::phase_t phase_q, phase_c, phase_d;
	logic [31:0] hbs_q, hbs_c, hbs_d;
	logic [31:0] hsize_q, hsize_c, hsize_d;
	logic [31:0] bstart_q, bstart_c, bstart_d;
	logic [2:0]  rbi_q, rbi_c, rbi_d;
	logic [31:0] tag_q, tag_c, tag_d;
	logic [31:0] len_q, len_c, len_d;
	logic [31:0] pleft_q, pleft_c, pleft_d;
	logic [3:0]  ppos_q, ppos_c, ppos_d;
	logic [2:0]  ctype_q, ctype_c, ctype_d;
	logic [3:0]  req_q, req_c, req_d;
	logic [15:0] width_q, width_c, width_d;
	logic [15:0] height_q, height_c, height_d;
	logic [15:0] col_q, col_c, col_d;
	logic [15:0] row_q, row_c, row_d;
	logic [1:0]  tri_q, tri_c, tri_d;
	logic [7:0]  held_q, held_c, held_d;

	rawdefrm_pkg::result_t res0, res1;
	logic [1:0] nres;

	// output queue
	rawdefrm_pkg::result_t qmem [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q <= (QAW+1)'(QDEPTH - 2));
	assign push = in_valid & in_ready;
	assign out_valid = (cnt_q != '0);
	assign pop = out_valid & out_ready;

	// start of file restarts from reset values
	always_comb begin
		if (start_of_file) begin
			phase_c = rawdefrm_pkg::PH_START;
			hbs_c = '0; hsize_c = '0; bstart_c = '0; rbi_c = '0; tag_c = '0;
			len_c = '0; pleft_c = '0; ppos_c = '0; ctype_c = '0; req_c = '0;
			width_c = '0; height_c = '0; col_c = '0; row_c = '0; tri_c = '0;
			held_c = '0;
		end else begin
			phase_c = phase_q;
			hbs_c = hbs_q; hsize_c = hsize_q; bstart_c = bstart_q; rbi_c = rbi_q;
			tag_c = tag_q; len_c = len_q; pleft_c = pleft_q; ppos_c = ppos_q;
			ctype_c = ctype_q; req_c = req_q; width_c = width_q; height_c = height_q;
			col_c = col_q; row_c = row_q; tri_c = tri_q; held_c = held_q;
		end
	end

	// byte parser: next state and results
	always_comb begin
		logic [31:0] sh;
		logic [16:0] col_next;
		logic [15:0] row_next;
		phase_d = phase_c;
		hbs_d = hbs_c; hsize_d = hsize_c; bstart_d = bstart_c; rbi_d = rbi_c;
		tag_d = tag_c; len_d = len_c; pleft_d = pleft_c; ppos_d = ppos_c;
		ctype_d = ctype_c; req_d = req_c; width_d = width_c; height_d = height_c;
		col_d = col_c; row_d = row_c; tri_d = tri_c; held_d = held_c;
		res0 = '0;
		res1 = '0;
		nres = 2'd0;
		sh = '0;
		col_next = '0;
		row_next = '0;
		unique case (phase_c)
			rawdefrm_pkg::PH_START: begin
				if (!rbi_c[2]) begin
					// magic bytes
					sh = {tag_c[23:0], data_byte};
					tag_d = sh;
					if (rbi_c == 3'd3 && sh != rawdefrm_pkg::TAG_MAGIC) begin
						res0.kind = rawdefrm_pkg::KIND_REJECT;
						res0.fail_cause = rawdefrm_pkg::FAIL_MAGIC;
						phase_d = rawdefrm_pkg::PH_IDLE;
						nres = 2'd1;
					end
					rbi_d = rbi_c + 3'd1;
				end else begin
					// header length
					sh = {hsize_c[23:0], data_byte};
					hsize_d = sh;
					if (rbi_c == 3'd7) begin
						rbi_d = '0;
						tag_d = '0;
						phase_d = rawdefrm_pkg::PH_HEADER;
						if (sh == '0) begin
							res0 = rawdefrm_pkg::judge_result(req_c, width_c, height_c);
							phase_d = rawdefrm_pkg::judge_phase(req_c, width_c, height_c);
							col_d = '0; row_d = '0; tri_d = '0; held_d = '0;
							nres = 2'd1;
						end
					end else begin
						rbi_d = rbi_c + 3'd1;
					end
				end
			end
			rawdefrm_pkg::PH_HEADER: begin
				if (pleft_c != '0) begin
					// block payload, PRD dimensions captured
					if (ctype_c == rawdefrm_pkg::BT_PRD) begin
						case (ppos_c)
							rawdefrm_pkg::POS_HEIGHT_HI: height_d[15:8] = data_byte;
							rawdefrm_pkg::POS_HEIGHT_LO: height_d[7:0] = data_byte;
							rawdefrm_pkg::POS_WIDTH_HI:  width_d[15:8] = data_byte;
							rawdefrm_pkg::POS_WIDTH_LO:  width_d[7:0] = data_byte;
							default: ;
						endcase
					end
					if (ppos_c != rawdefrm_pkg::POS_SAT) ppos_d = ppos_c + 4'd1;
					pleft_d = pleft_c - 32'd1;
				end else begin
					// block record: tag then length
					if (rbi_c == 3'd0) bstart_d = hbs_c;
					if (!rbi_c[2]) tag_d = {tag_c[23:0], data_byte};
					else len_d = {len_c[23:0], data_byte};
					if (rbi_c == 3'd7) begin
						ctype_d = rawdefrm_pkg::classify(tag_c);
						if (!ctype_d[2]) req_d[ctype_d[1:0]] = (len_d != '0);
						if (ctype_d == rawdefrm_pkg::BT_PRD) begin
							width_d = '0;
							height_d = '0;
						end
						res0.kind = rawdefrm_pkg::KIND_BLOCK;
						res0.block_type = ctype_d;
						res0.block_offset = bstart_c;
						res0.block_length = len_d;
						nres = 2'd1;
						pleft_d = len_d;
						ppos_d = '0;
						rbi_d = '0;
					end else begin
						rbi_d = rbi_c + 3'd1;
					end
				end
				hbs_d = hbs_c + 32'd1;
				if (hbs_d == hsize_c) begin
					if (nres == 2'd1) begin
						res1 = rawdefrm_pkg::judge_result(req_d, width_d, height_d);
						nres = 2'd2;
					end else begin
						res0 = rawdefrm_pkg::judge_result(req_d, width_d, height_d);
						nres = 2'd1;
					end
					phase_d = rawdefrm_pkg::judge_phase(req_d, width_d, height_d);
					col_d = '0; row_d = '0; tri_d = '0; held_d = '0;
				end
			end
			rawdefrm_pkg::PH_PIXELS: begin
				// two 12-bit pixels per three bytes
				case (tri_c)
					2'd0: begin
						held_d = data_byte;
						tri_d = 2'd1;
					end
					2'd1: begin
						res0.kind = rawdefrm_pkg::KIND_PIXEL;
						res0.pixel_value = {held_c, data_byte[7:4]};
						nres = 2'd1;
						held_d = data_byte;
						tri_d = 2'd2;
					end
					default: begin
						res0.kind = rawdefrm_pkg::KIND_PIXEL;
						res0.pixel_value = {held_c[3:0], data_byte};
						nres = 2'd1;
						tri_d = 2'd0;
						col_next = {1'b0, col_c} + 17'd2;
						col_d = col_next[15:0];
						if (col_next >= {1'b0, width_c}) begin
							col_d = '0;
							row_next = row_c + 16'd1;
							row_d = row_next;
							if (row_next >= height_c) begin
								res0.end_of_image = 1'b1;
								phase_d = rawdefrm_pkg::PH_IDLE;
							end
						end
					end
				endcase
			end
			rawdefrm_pkg::PH_IDLE: ;
			default: ;
		endcase
		if (nres == 2'd1) res0.last = 1'b1;
		if (nres == 2'd2) res1.last = 1'b1;
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rawdefrm_pkg::PH_START;
			hbs_q <= '0; hsize_q <= '0; bstart_q <= '0; rbi_q <= '0; tag_q <= '0;
			len_q <= '0; pleft_q <= '0; ppos_q <= '0; ctype_q <= '0; req_q <= '0;
			width_q <= '0; height_q <= '0; col_q <= '0; row_q <= '0; tri_q <= '0;
			held_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			hbs_q <= hbs_d; hsize_q <= hsize_d; bstart_q <= bstart_d; rbi_q <= rbi_d;
			tag_q <= tag_d; len_q <= len_d; pleft_q <= pleft_d; ppos_q <= ppos_d;
			ctype_q <= ctype_d; req_q <= req_d; width_q <= width_d; height_q <= height_d;
			col_q <= col_d; row_q <= row_d; tri_q <= tri_d; held_q <= held_d;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (push && nres != 2'd0) qmem[wr_q] <= res0;
		if (push && nres == 2'd2) qmem[wr_q + QAW'(1)] <= res1;
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QAW'(nres);
			if (pop) rd_q <= rd_q + QAW'(1);
			cnt_q <= cnt_q + (push ? (QAW+1)'(nres) : '0) - (QAW+1)'(pop);
		end
	end

	// head of queue
	assign kind = qmem[rd_q].kind;
	assign pixel_value = qmem[rd_q].pixel_value;
	assign block_type = qmem[rd_q].block_type;
	assign block_offset = qmem[rd_q].block_offset;
	assign block_length = qmem[rd_q].block_length;
	assign image_width = qmem[rd_q].image_width;
	assign image_height = qmem[rd_q].image_height;
	assign fail_cause = qmem[rd_q].fail_cause;
	assign end_of_image = qmem[rd_q].end_of_image;
	assign last = qmem[rd_q].last;

endmodule
